### design/assert_macros.svh
// Assertion macros shared by the shaded disc pixel generator RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with asynchronous active-low reset disable.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Clocked invariant with asynchronous active-low reset disable.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

### design/sdpg_pkg.sv
// Package for the shaded disc pixel generator: widths, stage counts, constants,
// register index codes and pipeline stage types. No dependencies.
package sdpg_pkg;

  localparam int FracBits    = 15;
  localparam int LightFrac   = 15;

  // Pipelined divider for the unit normal: (mag << FracBits) / radius
  localparam int DivNumW     = 9 + FracBits;
  localparam int QuoW        = FracBits + 1;
  localparam int DivSteps    = 4;
  localparam int DivStages   = DivNumW / DivSteps;

  // Pipelined integer square root of the z radicand
  localparam int RadW        = 2 * QuoW;
  localparam int RootW       = RadW / 2;
  localparam int SqrtSteps   = 4;
  localparam int SqrtStages  = RootW / SqrtSteps;
  localparam int SqrtRemW    = RootW + 2;

  // Pipeline bookkeeping: input line reaches stage 18, valid line ends at stage 19
  localparam int LineDepth   = 18;
  localparam int VldDepth    = 18;
  localparam int ProdDepth   = 6;
  localparam int Latency     = 19;

  localparam logic [33:0] UnitSq     = 34'(1) << (2 * FracBits);
  localparam logic [33:0] ShadeBias  = 34'(1) << (FracBits + LightFrac + 1);
  localparam logic [15:0] Div5Recip  = 16'd52429;
  localparam int          Div5Shift  = 18;

  // Reset values of the configuration registers
  localparam logic [15:0] BaseColor565 = 16'hFCA0;
  localparam logic [7:0]  RadiusRst    = 8'd8;
  localparam logic signed [15:0] LightXRst = 16'sd9830;

  typedef enum logic [3:0] {
    REG_RADIUS     = 4'd0,
    REG_CENTER_X   = 4'd1,
    REG_CENTER_Y   = 4'd2,
    REG_LIGHT_X    = 4'd3,
    REG_LIGHT_Y    = 4'd4,
    REG_BASE_RED   = 4'd5,
    REG_BASE_GREEN = 4'd6,
    REG_BASE_BLUE  = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]         rem;
    logic [DivNumW-1:0] num;
    logic [QuoW-1:0]    quo;
  } div_st_t;

  typedef struct packed {
    logic [SqrtRemW-1:0] rem;
    logic [RadW-1:0]     num;
    logic [RootW-1:0]    root;
  } sqrt_st_t;

  typedef struct packed {
    logic signed [8:0] dx;
    logic signed [8:0] dy;
  } offs_t;

endpackage

### design/sdpg_div.sv
// Pipelined restoring divider: quo = (mag << FracBits) / den, a few bits per stage.
// Depends on sdpg_pkg. Divisor must stay stable while items are in flight.
module sdpg_div import sdpg_pkg::*; (
  input  logic            clk_i,
  input  logic [8:0]      mag_i,
  input  logic [7:0]      den_i,
  output logic [QuoW-1:0] quo_o
);

  div_st_t st_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    div_st_t cur;
    div_st_t nxt;

    if (s == 0) begin : g_first
      assign cur = '{rem: '0, num: {mag_i, {FracBits{1'b0}}}, quo: '0};
    end else begin : g_next
      assign cur = st_q[s-1];
    end

    always_comb begin
      logic [8:0] trial;
      nxt = cur;
      for (int b = 0; b < DivSteps; b++) begin
        trial   = {nxt.rem, nxt.num[DivNumW-1]};
        nxt.num = {nxt.num[DivNumW-2:0], 1'b0};
        if (trial >= {1'b0, den_i}) begin
          nxt.rem = 8'(trial - {1'b0, den_i});
          nxt.quo = {nxt.quo[QuoW-2:0], 1'b1};
        end else begin
          nxt.rem = trial[7:0];
          nxt.quo = {nxt.quo[QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= nxt;
    end
  end

  assign quo_o = st_q[DivStages-1].quo;

endmodule

### design/sdpg_sqrt.sv
// Pipelined digit-by-digit integer square root, a few root bits per stage.
// Depends on sdpg_pkg.
module sdpg_sqrt import sdpg_pkg::*; (
  input  logic             clk_i,
  input  logic [RadW-1:0]  rad_i,
  output logic [RootW-1:0] root_o
);

  sqrt_st_t st_q [SqrtStages];

  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    sqrt_st_t cur;
    sqrt_st_t nxt;

    if (s == 0) begin : g_first
      assign cur = '{rem: '0, num: rad_i, root: '0};
    end else begin : g_next
      assign cur = st_q[s-1];
    end

    always_comb begin
      logic [SqrtRemW+1:0] acc;
      logic [SqrtRemW+1:0] cand;
      nxt = cur;
      for (int b = 0; b < SqrtSteps; b++) begin
        acc     = {nxt.rem, nxt.num[RadW-1:RadW-2]};
        cand    = (SqrtRemW+2)'({nxt.root, 2'b01});
        nxt.num = {nxt.num[RadW-3:0], 2'b00};
        if (acc >= cand) begin
          nxt.rem  = SqrtRemW'(acc - cand);
          nxt.root = {nxt.root[RootW-2:0], 1'b1};
        end else begin
          nxt.rem  = SqrtRemW'(acc);
          nxt.root = {nxt.root[RootW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= nxt;
    end
  end

  assign root_o = st_q[SqrtStages-1].root;

endmodule

### design/sdpg_shade.sv
// One colour lane: scale a base component by the brightness term, divide by
// 5 * 2^30 and saturate at 255. Two register stages. Depends on sdpg_pkg.
module sdpg_shade import sdpg_pkg::*; (
  input  logic        clk_i,
  input  logic [7:0]  base_i,
  input  logic [33:0] scale_i,
  output logic [7:0]  color_o
);

  logic [41:0] prod_q;
  logic [11:0] coarse;
  logic [27:0] recip_prod;
  logic [9:0]  quot;
  logic [7:0]  color_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 42'(base_i) * 42'(scale_i);
  end

  // Divide by 2^30 with a shift, then by 5 with a reciprocal multiply
  assign coarse     = prod_q[41:30];
  assign recip_prod = 28'(coarse) * 28'(Div5Recip);
  assign quot       = recip_prod[27:Div5Shift];

  always_ff @(posedge clk_i) begin
    color_q <= (quot > 10'd255) ? 8'hFF : quot[7:0];
  end

  assign color_o = color_q;

endmodule

### design/shaded_disc_pixel_generator.sv
// Top level of the shaded disc pixel generator: config registers, pipeline
// control, normal, dot product and colour stages. Depends on sdpg_pkg,
// sdpg_div, sdpg_sqrt, sdpg_shade and assert_macros.svh.
//
//  channel   handshake                      payload
//  -------   -----------------------------  ------------------------------------
//  input     start_i & !busy_o              offset_x_i, offset_y_i
//  result    pixel_valid_o (one cycle)      pixel_x_o, pixel_y_o, red/green/blue_o
//  config    cfg_valid_i & cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item enters every cycle; busy_o stays low. Each result passes through the
// 6-stage divider and the 4-stage square root on its way to the outputs.
// Items outside the disc, or taken while the radius is zero, travel as bubbles
// and give no strobe. Reset clears the valid line and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module shaded_disc_pixel_generator import sdpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [8:0]  offset_x_i,
  input  logic signed [8:0]  offset_y_i,
  output logic               pixel_valid_o,
  output logic signed [12:0] pixel_x_o,
  output logic signed [12:0] pixel_y_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // Configuration registers
  logic [7:0]         radius_q;
  logic [10:0]        center_x_q;
  logic [10:0]        center_y_q;
  logic signed [15:0] light_x_q;
  logic signed [15:0] light_y_q;
  logic [7:0]         base_red_q;
  logic [7:0]         base_green_q;
  logic [7:0]         base_blue_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= RadiusRst;
      center_x_q   <= '0;
      center_y_q   <= '0;
      light_x_q    <= LightXRst;
      light_y_q    <= '0;
      base_red_q   <= {BaseColor565[15:11], 3'b000};
      base_green_q <= {BaseColor565[10:5], 2'b00};
      base_blue_q  <= {BaseColor565[4:0], 3'b000};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RADIUS:     radius_q     <= cfg_data_i[7:0];
        REG_CENTER_X:   center_x_q   <= cfg_data_i[10:0];
        REG_CENTER_Y:   center_y_q   <= cfg_data_i[10:0];
        REG_LIGHT_X:    light_x_q    <= cfg_data_i;
        REG_LIGHT_Y:    light_y_q    <= cfg_data_i;
        REG_BASE_RED:   base_red_q   <= cfg_data_i[7:0];
        REG_BASE_GREEN: base_green_q <= cfg_data_i[7:0];
        REG_BASE_BLUE:  base_blue_q  <= cfg_data_i[7:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Stage 1: take the item, split offsets into magnitude and sign
  logic       accept;
  logic       v1_q;
  logic [8:0] magx1_q, magy1_q;
  offs_t      line_q [LineDepth];

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    magx1_q   <= offset_x_i[8] ? 9'(-offset_x_i) : offset_x_i;
    magy1_q   <= offset_y_i[8] ? 9'(-offset_y_i) : offset_y_i;
    line_q[0] <= '{dx: offset_x_i, dy: offset_y_i};
    for (int k = 1; k < LineDepth; k++) begin
      line_q[k] <= line_q[k-1];
    end
  end

  // Stage 2: disc test; bubbles for points outside or a zero radius
  logic [18:0] dist_sq;
  logic [15:0] rad_sq;
  logic        in_disc;
  logic [8:0]  magx2_q, magy2_q;
  logic        vld_q [VldDepth];

  assign dist_sq = 19'(magx1_q) * 19'(magx1_q) + 19'(magy1_q) * 19'(magy1_q);
  assign rad_sq  = radius_q * radius_q;
  assign in_disc = (radius_q != '0) && (dist_sq <= 19'(rad_sq));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VldDepth; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= v1_q && in_disc;
      for (int k = 1; k < VldDepth; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    magx2_q <= magx1_q;
    magy2_q <= magy1_q;
  end

  // Stages 3 to 8: divide the magnitudes by the radius
  logic [QuoW-1:0] qx, qy;

  sdpg_div u_div_x (.clk_i, .mag_i(magx2_q), .den_i(radius_q), .quo_o(qx));
  sdpg_div u_div_y (.clk_i, .mag_i(magy2_q), .den_i(radius_q), .quo_o(qy));

  // Stage 9: restore the sign of the normal components
  logic signed [16:0] nx_q, ny_q;
  logic [QuoW-1:0]    qx_q, qy_q;

  always_ff @(posedge clk_i) begin
    nx_q <= line_q[7].dx[8] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    ny_q <= line_q[7].dy[8] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    qx_q <= qx;
    qy_q <= qy;
  end

  // Stage 10: squares for the radicand, light products for the dot product
  logic [31:0]        nx2_q, ny2_q;
  logic signed [32:0] prod_x_q [ProdDepth];
  logic signed [32:0] prod_y_q [ProdDepth];

  always_ff @(posedge clk_i) begin
    nx2_q       <= qx_q * qx_q;
    ny2_q       <= qy_q * qy_q;
    prod_x_q[0] <= 33'(nx_q) * 33'(light_x_q);
    prod_y_q[0] <= 33'(ny_q) * 33'(light_y_q);
    for (int k = 1; k < ProdDepth; k++) begin
      prod_x_q[k] <= prod_x_q[k-1];
      prod_y_q[k] <= prod_y_q[k-1];
    end
  end

  // Stage 11: radicand 1 - nx^2 - ny^2, clamped at zero
  logic signed [33:0] rad_s;
  logic [RadW-1:0]    rad_q;

  assign rad_s = $signed(UnitSq) - $signed(34'(nx2_q)) - $signed(34'(ny2_q));

  always_ff @(posedge clk_i) begin
    rad_q <= rad_s[33] ? '0 : rad_s[RadW-1:0];
  end

  // Stages 12 to 15: nz
  logic [RootW-1:0] nz;

  sdpg_sqrt u_sqrt (.clk_i, .rad_i(rad_q), .root_o(nz));

  // Stage 16: dot product with the light, clamped at zero
  logic signed [34:0] dot_sum;
  logic [31:0]        dotp_q;

  assign dot_sum = 35'(prod_x_q[ProdDepth-1]) + 35'(prod_y_q[ProdDepth-1])
                 + 35'($signed({1'b0, nz, {LightFrac{1'b0}}}));

  always_ff @(posedge clk_i) begin
    dotp_q <= dot_sum[34] ? '0 : dot_sum[31:0];
  end

  // Stage 17: brightness numerator 2*one + 3*dot
  logic [33:0] scale_q;

  always_ff @(posedge clk_i) begin
    scale_q <= ShadeBias + 34'(dotp_q) + {1'b0, dotp_q, 1'b0};
  end

  // Stages 18 and 19: scale each base colour
  sdpg_shade u_shade_r (.clk_i, .base_i(base_red_q),   .scale_i(scale_q), .color_o(red_o));
  sdpg_shade u_shade_g (.clk_i, .base_i(base_green_q), .scale_i(scale_q), .color_o(green_o));
  sdpg_shade u_shade_b (.clk_i, .base_i(base_blue_q),  .scale_i(scale_q), .color_o(blue_o));

  // Stage 19: screen position
  logic signed [12:0] pix_x_q, pix_y_q;

  always_ff @(posedge clk_i) begin
    pix_x_q <= $signed({2'b00, center_x_q}) + 13'(line_q[LineDepth-1].dx);
    pix_y_q <= $signed({2'b00, center_y_q}) + 13'(line_q[LineDepth-1].dy);
  end

  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_valid_o = vld_q[VldDepth-1];

  // Checks
  `ASSERT_IMP(a_strobe_has_item, clk_i, rst_ni, pixel_valid_o,
              $past(start_i && !busy_o, Latency), "result without an item")
  `ASSERT_IMP(a_far_offset_drops, clk_i, rst_ni,
              $past(start_i && offset_x_i == 9'sh100, Latency), !pixel_valid_o,
              "offset beyond any radius gave a result")
  `ASSERT_IMP(a_nz_bound, clk_i, rst_ni, vld_q[13],
              nz <= (RootW'(1) << FracBits), "nz above one")
  `ASSERT_IMP(a_dot_bound, clk_i, rst_ni, vld_q[14],
              dotp_q < 32'hC000_0000, "dot product out of range")

endmodule
